// ===== hdl/pdis_pkg.sv =====
// ----------------------------------------------------------------------------
// pdis_pkg
// Shared types and constants for the positional PID step with dead zone,
// error cutoff and integral separation.
// ----------------------------------------------------------------------------
package pdis_pkg;

   // csr address and data widths
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   // field widths
   localparam int ValueWidth  = 16;   // measured, setpoint, drive
   localparam int ErrWidth    = 17;   // setpoint - measured
   localparam int GainWidth   = 16;   // Q8.8 gains
   localparam int LimitWidth  = 15;   // clamp magnitudes in output units
   localparam int MagWidth    = 16;   // cutoff, dead zone, separation
   localparam int IntegWidth  = 24;   // integrator, Q.8
   localparam int FracBits    = 8;

   // register reset values
   localparam logic [LimitWidth-1:0] IntegralLimitReset = 15'd32767;
   localparam logic [LimitWidth-1:0] OutputLimitReset   = 15'd32767;
   localparam logic [MagWidth-1:0]   ErrorCutoffReset   = 16'd0;
   localparam logic [MagWidth-1:0]   DeadZoneReset      = 16'd5;
   localparam logic [MagWidth-1:0]   SeparationReset    = 16'd1000;

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_GAIN_P         = 3'd0,
      REG_GAIN_I         = 3'd1,
      REG_GAIN_D         = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_OUTPUT_LIMIT   = 3'd4,
      REG_ERROR_CUTOFF   = 3'd5,
      REG_DEAD_ZONE      = 3'd6,
      REG_SEPARATION     = 3'd7
   } csr_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_COMPUTED  = 2'd0,
      STATUS_DEAD_ZONE = 2'd1,
      STATUS_CUTOFF    = 2'd2
   } status_type;

endpackage

// ===== hdl/pid_deadband_integral_separation.sv =====
// ----------------------------------------------------------------------------
// pid_deadband_integral_separation
// Positional PID step in fixed point with error cutoff, dead zone, integral
// separation and clamped integrator and drive.
// ----------------------------------------------------------------------------
//
//   channel   direction  beat contents
//   req_*     in         tdata: measured [15:0], setpoint [31:16]
//   rsp_*     out        tdata: drive [15:0]; tuser: status [1:0]
//   csr_*     in         8 registers at byte addresses 0x00 .. 0x1c
//
// One beat per cycle sustained while rsp_tready stays high. A request beat
// is registered as its error, the PID step then runs on it against the
// integrator and previous error registers, and the result lands in the
// output register. State is updated as each beat leaves the error stage, so
// beats that follow back to back see it at once. A stalled rsp side holds
// one result in the output register and one in the error stage before
// req_tready drops. Reset is synchronous; it clears the state and restores
// the register defaults.
//
module pid_deadband_integral_separation (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // measured [15:0], setpoint [31:16]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drive [15:0]
   output logic [1:0]  rsp_tuser,   // status [1:0]
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pdis_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [pdis_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [pdis_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                               csr_pready
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic signed [pdis_pkg::GainWidth-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [pdis_pkg::LimitWidth-1:0]        integral_limit_ff, output_limit_ff;
   logic [pdis_pkg::MagWidth-1:0]          error_cutoff_ff, dead_zone_ff;
   logic [pdis_pkg::MagWidth-1:0]          separation_ff;
   logic                                   csr_write;
   pdis_pkg::csr_index_type                csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = pdis_pkg::csr_index_type'(csr_paddr[4:2]);

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         integral_limit_ff <= pdis_pkg::IntegralLimitReset;
         output_limit_ff   <= pdis_pkg::OutputLimitReset;
         error_cutoff_ff   <= pdis_pkg::ErrorCutoffReset;
         dead_zone_ff      <= pdis_pkg::DeadZoneReset;
         separation_ff     <= pdis_pkg::SeparationReset;
      end else if (csr_write) begin
         unique case (csr_index)
            pdis_pkg::REG_GAIN_P:         gain_p_ff <= $signed(csr_pwdata[15:0]);
            pdis_pkg::REG_GAIN_I:         gain_i_ff <= $signed(csr_pwdata[15:0]);
            pdis_pkg::REG_GAIN_D:         gain_d_ff <= $signed(csr_pwdata[15:0]);
            pdis_pkg::REG_INTEGRAL_LIMIT: integral_limit_ff <= csr_pwdata[14:0];
            pdis_pkg::REG_OUTPUT_LIMIT:   output_limit_ff <= csr_pwdata[14:0];
            pdis_pkg::REG_ERROR_CUTOFF:   error_cutoff_ff <= csr_pwdata[15:0];
            pdis_pkg::REG_DEAD_ZONE:      dead_zone_ff <= csr_pwdata[15:0];
            pdis_pkg::REG_SEPARATION:     separation_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         pdis_pkg::REG_GAIN_P:         csr_prdata = {16'd0, gain_p_ff};
         pdis_pkg::REG_GAIN_I:         csr_prdata = {16'd0, gain_i_ff};
         pdis_pkg::REG_GAIN_D:         csr_prdata = {16'd0, gain_d_ff};
         pdis_pkg::REG_INTEGRAL_LIMIT: csr_prdata = {17'd0, integral_limit_ff};
         pdis_pkg::REG_OUTPUT_LIMIT:   csr_prdata = {17'd0, output_limit_ff};
         pdis_pkg::REG_ERROR_CUTOFF:   csr_prdata = {16'd0, error_cutoff_ff};
         pdis_pkg::REG_DEAD_ZONE:      csr_prdata = {16'd0, dead_zone_ff};
         pdis_pkg::REG_SEPARATION:     csr_prdata = {16'd0, separation_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // beat flow control
   // ------------------------------------------------------------------
   logic err_valid_ff, err_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire, step_go;

   assign step_go    = err_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~err_valid_ff | step_go;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      err_valid_in = err_valid_ff;
      if (req_fire)     err_valid_in = 1'b1;
      else if (step_go) err_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (step_go)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         err_valid_ff <= err_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // error stage: register setpoint - measured and its magnitude
   // ------------------------------------------------------------------
   logic signed [pdis_pkg::ErrWidth-1:0] err_in, err_ff;
   logic [pdis_pkg::ErrWidth-1:0]        mag_in, mag_ff;
   logic signed [pdis_pkg::ValueWidth-1:0] req_measured, req_setpoint;

   assign req_measured = $signed(req_tdata[15:0]);
   assign req_setpoint = $signed(req_tdata[31:16]);
   assign err_in = $signed({req_setpoint[15], req_setpoint})
                 - $signed({req_measured[15], req_measured});
   assign mag_in = err_in[16] ? 17'(-err_in) : 17'(err_in);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         err_ff <= err_in;
         mag_ff <= mag_in;
      end
   end

   // ------------------------------------------------------------------
   // PID step
   // ------------------------------------------------------------------
   logic signed [pdis_pkg::ErrWidth-1:0]   prev_err_ff, prev_err_in;
   logic signed [pdis_pkg::IntegWidth-1:0] integ_ff, integ_in, integ_clamped;
   logic signed [17:0]  err_diff;
   logic signed [32:0]  p_term, i_incr;
   logic signed [33:0]  d_term, integ_acc, ilim_pos, ilim_neg;
   logic signed [34:0]  pid_sum, olim_pos, olim_neg, sum_clamped;
   logic                hit_cutoff, hit_dead_zone, integrate;
   pdis_pkg::status_type step_status;
   logic signed [pdis_pkg::ValueWidth-1:0] step_drive;

   // case decisions
   assign hit_cutoff    = (error_cutoff_ff != '0) & (mag_ff > {1'b0, error_cutoff_ff});
   assign hit_dead_zone = (mag_ff <= {1'b0, dead_zone_ff});
   assign integrate     = (mag_ff <= {1'b0, separation_ff});

   // the three products, in parallel
   assign err_diff = $signed({err_ff[16], err_ff}) - $signed({prev_err_ff[16], prev_err_ff});
   assign p_term   = gain_p_ff * err_ff;
   assign i_incr   = gain_i_ff * err_ff;
   assign d_term   = gain_d_ff * err_diff;

   // integrator update and clamp
   assign ilim_pos  = $signed({11'd0, integral_limit_ff, 8'd0});
   assign ilim_neg  = -ilim_pos;
   assign integ_acc = $signed({{10{integ_ff[23]}}, integ_ff})
                    + (integrate ? $signed({i_incr[32], i_incr}) : 34'sd0);

   always_comb begin
      priority if (integ_acc > ilim_pos) integ_clamped = ilim_pos[23:0];
      else if (integ_acc < ilim_neg)     integ_clamped = ilim_neg[23:0];
      else                               integ_clamped = integ_acc[23:0];
   end

   // output sum, clamp and floor to integer
   assign olim_pos = $signed({12'd0, output_limit_ff, 8'd0});
   assign olim_neg = -olim_pos;
   assign pid_sum  = $signed({{2{p_term[32]}}, p_term})
                   + $signed({{11{integ_clamped[23]}}, integ_clamped})
                   + $signed({d_term[33], d_term});

   always_comb begin
      priority if (pid_sum > olim_pos) sum_clamped = olim_pos;
      else if (pid_sum < olim_neg)     sum_clamped = olim_neg;
      else                             sum_clamped = pid_sum;
   end

   // case selection for result and state
   always_comb begin
      integ_in    = integ_ff;
      prev_err_in = prev_err_ff;
      priority if (hit_cutoff) begin
         step_status = pdis_pkg::STATUS_CUTOFF;
         step_drive  = '0;
      end else if (hit_dead_zone) begin
         step_status = pdis_pkg::STATUS_DEAD_ZONE;
         step_drive  = '0;
         prev_err_in = err_ff;
      end else begin
         step_status = pdis_pkg::STATUS_COMPUTED;
         step_drive  = sum_clamped[23:8];
         prev_err_in = err_ff;
         integ_in    = integ_clamped;
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else if (step_go) begin
         integ_ff    <= integ_in;
         prev_err_ff <= prev_err_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   logic [pdis_pkg::ValueWidth-1:0] rsp_drive_ff;
   pdis_pkg::status_type            rsp_status_ff;

   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_drive_ff  <= step_drive;
         rsp_status_ff <= step_status;
      end
   end

   assign rsp_tdata = rsp_drive_ff;
   assign rsp_tuser = rsp_status_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // both stages full and rsp stalled: no new beat may enter
   assert property (@(posedge clock) disable iff (reset)
      (err_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both stages are full");

   // drive is zero unless the step was computed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != pdis_pkg::STATUS_COMPUTED) |-> (rsp_drive_ff == '0))
      else $error("nonzero drive on dead zone or cutoff result");

   // a cutoff step leaves the controller state alone
   assert property (@(posedge clock) disable iff (reset)
      (step_go && hit_cutoff) |=> ($stable(integ_ff) && $stable(prev_err_ff)))
      else $error("state changed on cutoff step");

   // integrator stays within the limit it was clamped to
   assert property (@(posedge clock) disable iff (reset)
      (step_go && !hit_cutoff && !hit_dead_zone) |=>
         ($signed({{10{integ_ff[23]}}, integ_ff}) <= $past(ilim_pos) &&
          $signed({{10{integ_ff[23]}}, integ_ff}) >= $past(ilim_neg)))
      else $error("integrator outside its clamp");

endmodule
